// ===== rtl/pira_pkg.sv =====
// Shared types and codes for the positional insert/remove list.
`default_nettype none
package pira_pkg;

	localparam logic [1:0] ACT_INSERT   = 2'd0;
	localparam logic [1:0] ACT_REMOVE   = 2'd1;
	localparam logic [1:0] ACT_TRAVERSE = 2'd2;
	localparam logic [1:0] ACT_UNUSED   = 2'd3;

	localparam logic [1:0] ST_DONE    = 2'd0;
	localparam logic [1:0] ST_IGNORED = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;
	localparam logic [1:0] ST_EMPTY   = 2'd3;

	typedef struct packed {
		logic [1:0]         action;
		logic signed [15:0] position;
		logic [31:0]        element_in;
	} cmd_t;

	typedef struct packed {
		logic [31:0] element_out;
		logic [5:0]  slot_index;
		logic [6:0]  count_after;
		logic [1:0]  status;
		logic        last;
	} result_t;

endpackage
`default_nettype wire

// ===== rtl/positional_insert_remove_array.sv =====
// Top level: command decode and shift sequencer around the element store.
//
// Ordered list of up to CAPACITY elements held in a single-port-write,
// single-port-read memory. A command is taken when start is high and busy is
// low; busy stays high until the command has finished. Zero elements,
// refused inserts, invalid removes, empty traverses and the unused action
// code give their single result in the cycle after the transfer. An insert
// at position k into a list of n entries moves n-k entries up, one per cycle
// through the memory's read and write ports, and then reports its result; a
// remove at k moves n-k-1 entries down and then reports. A traverse streams
// its n results one per cycle, the last one flagged. Every result is shown
// on result for one cycle with strobe high and must be taken then: there is
// no back-pressure. The store is not cleared at reset; only entries below
// the count are ever read.
`default_nettype none
module positional_insert_remove_array
	import pira_pkg::*;
#(
	parameter int CAPACITY     = 64,
	parameter int ELEMENT_BITS = 32
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    start,
	input  wire cmd_t    cmd,
	output logic         busy,
	output logic         strobe,
	output result_t      result
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int EW = (ELEMENT_BITS < 32) ? ELEMENT_BITS : 32;

	typedef enum logic {S_IDLE, S_SHIFT} state_t;

	state_t        state_q;
	logic [1:0]    mode_q;
	logic [CW-1:0] count_q;
	logic [AW-1:0] ptr_q;
	logic [AW-1:0] end_q;
	logic [AW-1:0] wa_q;
	logic [AW-1:0] at_q;
	logic [EW-1:0] elem_q;
	logic          more_q;
	logic          live_q;
	logic          strobe_q;
	result_t       result_q;

	logic          accept;
	logic [EW-1:0] elem;
	logic          pos_neg;
	logic [15:0]   pos_u;
	logic [15:0]   count16;
	logic          append;
	logic [15:0]   ins_at16;
	logic [AW-1:0] ins_at;
	logic [AW-1:0] rem_at;
	logic          rem_ok;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [EW-1:0] mem_wdata;
	logic          mem_re;
	logic [EW-1:0] mem_rdata;
	logic [AW-1:0] wa_next;
	logic [AW-1:0] ptr_next;
	logic          trav_last;
	logic          imm_done;
	logic [1:0]    imm_status;
	logic          strobe_d;

	assign accept   = start && (state_q == S_IDLE);
	assign elem     = cmd.element_in[EW-1:0];
	assign pos_neg  = cmd.position[15];
	assign pos_u    = {1'b0, cmd.position[14:0]};
	assign count16  = 16'(count_q);
	assign append   = pos_neg || (pos_u > count16);
	assign ins_at16 = append ? count16 : pos_u;
	assign ins_at   = ins_at16[AW-1:0];
	assign rem_ok   = !pos_neg && (pos_u < count16);
	assign rem_at   = pos_u[AW-1:0];

	// Commands that finish on the transfer and the status they report.
	always_comb begin
		imm_done   = 1'b1;
		imm_status = ST_IGNORED;
		unique case (cmd.action)
			ACT_INSERT: begin
				if (elem == '0) begin
					imm_status = ST_IGNORED;
				end else if (count_q == CW'(CAPACITY)) begin
					imm_status = ST_FULL;
				end else begin
					imm_done = 1'b0;
				end
			end
			ACT_REMOVE: begin
				imm_done = !rem_ok;
			end
			ACT_TRAVERSE: begin
				if (count_q == '0) begin
					imm_status = ST_EMPTY;
				end else begin
					imm_done = 1'b0;
				end
			end
			default: begin
				imm_done = 1'b1;
			end
		endcase
	end

	// Insert walks down (read i, write i+1); remove and traverse walk up.
	always_comb begin
		wa_next  = ptr_q;
		ptr_next = ptr_q + AW'(1);
		if (mode_q == ACT_INSERT) begin
			wa_next  = ptr_q + AW'(1);
			ptr_next = ptr_q - AW'(1);
		end else if (mode_q == ACT_REMOVE) begin
			wa_next = ptr_q - AW'(1);
		end
	end

	assign mem_re    = (state_q == S_SHIFT) && more_q;
	assign mem_we    = (state_q == S_SHIFT) &&
		((live_q && (mode_q != ACT_TRAVERSE)) ||
		 (!live_q && !more_q && (mode_q == ACT_INSERT)));
	assign mem_waddr = live_q ? wa_q : at_q;
	assign mem_wdata = live_q ? mem_rdata : elem_q;
	assign trav_last = ((CW'(wa_q) + CW'(1)) == count_q);

	assign strobe_d  = (accept && imm_done) ||
		((state_q == S_SHIFT) && live_q && (mode_q == ACT_TRAVERSE)) ||
		((state_q == S_SHIFT) && !live_q && !more_q &&
		 ((mode_q == ACT_INSERT) || (mode_q == ACT_REMOVE)));

	pira_mem #(
		.DEPTH(CAPACITY),
		.WIDTH(EW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (ptr_q),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			mode_q   <= ACT_INSERT;
			count_q  <= '0;
			ptr_q    <= '0;
			end_q    <= '0;
			wa_q     <= '0;
			at_q     <= '0;
			elem_q   <= '0;
			more_q   <= 1'b0;
			live_q   <= 1'b0;
			strobe_q <= 1'b0;
			result_q <= '0;
		end else begin
			strobe_q <= strobe_d;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						mode_q   <= cmd.action;
						elem_q   <= elem;
						live_q   <= 1'b0;
						result_q <= '{element_out: '0, slot_index: '0,
							count_after: 7'(count_q), status: imm_status, last: 1'b1};
						if (!imm_done) begin
							state_q <= S_SHIFT;
							unique case (cmd.action)
								ACT_INSERT: begin
									at_q   <= ins_at;
									ptr_q  <= AW'(count_q - CW'(1));
									end_q  <= ins_at;
									more_q <= (CW'(ins_at) != count_q);
								end
								ACT_REMOVE: begin
									at_q   <= rem_at;
									ptr_q  <= rem_at + AW'(1);
									end_q  <= AW'(count_q - CW'(1));
									more_q <= ((CW'(rem_at) + CW'(1)) != count_q);
								end
								ACT_TRAVERSE: begin
									ptr_q  <= '0;
									end_q  <= AW'(count_q - CW'(1));
									more_q <= 1'b1;
								end
								default: begin
									more_q <= 1'b0;
								end
							endcase
						end
					end
				end
				S_SHIFT: begin
					// Issue the next read while the previous word lands.
					if (more_q) begin
						wa_q   <= wa_next;
						ptr_q  <= ptr_next;
						more_q <= (ptr_q != end_q);
						live_q <= 1'b1;
					end else begin
						live_q <= 1'b0;
					end
					if (live_q && (mode_q == ACT_TRAVERSE)) begin
						result_q <= '{element_out: 32'(mem_rdata), slot_index: 6'(wa_q),
							count_after: 7'(count_q), status: ST_DONE, last: trav_last};
					end
					if (!live_q && !more_q) begin
						state_q <= S_IDLE;
						if (mode_q == ACT_INSERT) begin
							count_q  <= count_q + CW'(1);
							result_q <= '{element_out: '0, slot_index: 6'(at_q),
								count_after: 7'(count_q + CW'(1)), status: ST_DONE,
								last: 1'b1};
						end else if (mode_q == ACT_REMOVE) begin
							count_q  <= count_q - CW'(1);
							result_q <= '{element_out: '0, slot_index: 6'(at_q),
								count_after: 7'(count_q - CW'(1)), status: ST_DONE,
								last: 1'b1};
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign strobe = strobe_q;
	assign result = result_q;

	// A traverse streams its results without gaps up to the last one.
	a_stream_gapless: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !result.last) |=> strobe)
		else $error("traverse stream broke before last");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("stored count above capacity");

	a_count_reported: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (result.count_after == 7'(count_q)))
		else $error("reported count differs from stored count");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && !start) |=> !strobe)
		else $error("result without a command");

	a_no_write_traverse: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SHIFT && mode_q == ACT_TRAVERSE) |-> !mem_we)
		else $error("store written during traverse");

endmodule
`default_nettype wire

// ===== rtl/pira_mem.sv =====
// Element store: one write port, one read port with registered read data.
`default_nettype none
module pira_mem #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire
